// ===== rtl/fcpa_pkg.sv =====
`timescale 1ns / 1ps

package fcpa_pkg;

  // field and register widths
  localparam int ADDR_W       = 32;
  localparam int SIZE_W       = 21;
  localparam int COUNT_W      = 7;
  localparam int STATUS_W     = 2;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 32;
  localparam int STEP_W       = 5;
  localparam int DIV_STEPS    = 32;

  // parameter defaults and register reset values
  localparam int DEF_MAX_CHUNKS = 64;
  localparam logic [ADDR_W-1:0]  RST_BASE   = '0;
  localparam logic [SIZE_W-1:0]  RST_CHUNK  = SIZE_W'(64);
  localparam logic [COUNT_W-1:0] RST_CHUNKS = COUNT_W'(64);

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BASE_ADDRESS  = 2'd0,
    REG_CHUNK_BYTES   = 2'd1,
    REG_CHUNKS_IN_USE = 2'd2
  } cfg_reg_t;

  // result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_NO_ROOM  = 2'd1,
    ST_FREE_REJ = 2'd2
  } status_t;

  // request kinds
  typedef enum logic {
    MODE_ALLOC = 1'b0,
    MODE_FREE  = 1'b1
  } mode_t;

  // shared arithmetic unit operations
  typedef enum logic {
    OP_MUL = 1'b0,
    OP_DIV = 1'b1
  } arith_op_t;

  typedef struct packed {
    logic      start;
    arith_op_t op;
  } arith_ctrl_t;

  // sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN_A,
    S_READ,
    S_MUL,
    S_DIV,
    S_SCAN_F,
    S_DONE
  } state_t;

endpackage

// ===== rtl/fcpa_if.sv =====
`timescale 1ns / 1ps

// request channel
interface fcpa_req_if;
  import fcpa_pkg::*;

  logic              valid;
  logic              ready;
  logic              mode;
  logic [ADDR_W-1:0] free_address;

  modport source (output valid, output mode, output free_address, input ready);
  modport sink   (input valid, input mode, input free_address, output ready);
endinterface

// result channel
interface fcpa_rsp_if;
  import fcpa_pkg::*;

  logic                valid;
  logic                ready;
  logic [ADDR_W-1:0]   chunk_address;
  logic [STATUS_W-1:0] status;

  modport source (output valid, output chunk_address, output status, input ready);
  modport sink   (input valid, input chunk_address, input status, output ready);
endinterface

// ===== rtl/fcpa_ram.sv =====
`timescale 1ns / 1ps

module fcpa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/fcpa_arith.sv =====
`timescale 1ns / 1ps

module fcpa_arith #(
  parameter int IDX_W = 6
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  fcpa_pkg::arith_ctrl_t        ctrl,
  input  logic [fcpa_pkg::ADDR_W-1:0]  opnd_a,
  input  logic [fcpa_pkg::SIZE_W-1:0]  size,
  input  logic [IDX_W-1:0]             mult,
  output logic                         done,
  output logic [fcpa_pkg::ADDR_W-1:0]  result
);
  import fcpa_pkg::*;

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  arith_op_t         op_r, op_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic [ADDR_W-1:0] acc_r, acc_nxt;
  logic [ADDR_W-1:0] dq_r, dq_nxt;
  logic [IDX_W-1:0]  mult_r, mult_nxt;

  logic [SIZE_W:0]   shifted;
  logic [ADDR_W:0]   add_a, add_b, sum;
  logic              sub;

  // shared adder: restoring division step or shift-add multiply step
  always_comb begin
    shifted = {acc_r[SIZE_W-1:0], dq_r[ADDR_W-1]};
    if (op_r == OP_DIV) begin
      add_a = (ADDR_W+1)'(shifted);
      add_b = (ADDR_W+1)'(size);
      sub   = 1'b1;
    end else begin
      add_a = {1'b0, acc_r};
      add_b = {1'b0, dq_r};
      sub   = 1'b0;
    end
    sum = add_a + (sub ? ~add_b : add_b) + (ADDR_W+1)'(sub);
  end

  // step sequencing
  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    op_nxt   = op_r;
    step_nxt = step_r;
    acc_nxt  = acc_r;
    dq_nxt   = dq_r;
    mult_nxt = mult_r;
    if (ctrl.start) begin
      busy_nxt = 1'b1;
      op_nxt   = ctrl.op;
      if (ctrl.op == OP_DIV) begin
        acc_nxt  = '0;
        dq_nxt   = opnd_a;
        step_nxt = STEP_W'(DIV_STEPS - 1);
      end else begin
        acc_nxt  = opnd_a;
        dq_nxt   = ADDR_W'(size);
        mult_nxt = mult;
        step_nxt = STEP_W'(IDX_W - 1);
      end
    end else if (busy_r) begin
      if (op_r == OP_DIV) begin
        acc_nxt = sum[ADDR_W] ? ADDR_W'(shifted[SIZE_W-1:0])
                              : ADDR_W'(sum[SIZE_W-1:0]);
        dq_nxt  = {dq_r[ADDR_W-2:0], ~sum[ADDR_W]};
      end else begin
        if (mult_r[0]) begin
          acc_nxt = sum[ADDR_W-1:0];
        end
        dq_nxt   = {dq_r[ADDR_W-2:0], 1'b0};
        mult_nxt = mult_r >> 1;
      end
      if (step_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        step_nxt = step_r - STEP_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    op_r   <= op_nxt;
    step_r <= step_nxt;
    acc_r  <= acc_nxt;
    dq_r   <= dq_nxt;
    mult_r <= mult_nxt;
  end

  assign done   = done_r;
  assign result = (op_r == OP_DIV) ? dq_r : acc_r;

endmodule

// ===== rtl/fixed_chunk_pool_allocator.sv =====
`timescale 1ns / 1ps

// channel   dir  handshake      payload
// in_chan   in   valid/ready    mode, free_address
// out_chan  out  valid/ready    chunk_address, status
// cfg_*     in   cfg_we         cfg_index, cfg_wdata (no read-back)
//
// one request at a time; in_chan.ready is high only while the sequencer idles
// fresh allocate: one shift-add multiply of the bump counter by the chunk size, onto the base
// table allocate: scan for the lowest recorded slot (one slot per cycle), read its index, then multiply
// free: restoring divide of the offset by the chunk size, then a scan for the lowest empty slot
// reset clears the counter and all slot valid bits at once; no clearing pass
// the result register holds while out_chan.ready is low; the next request is taken meanwhile

module fixed_chunk_pool_allocator #(
  parameter int MAX_CHUNKS = fcpa_pkg::DEF_MAX_CHUNKS
) (
  input  logic                            clk,
  input  logic                            rst_n,
  fcpa_req_if.sink                        in_chan,
  fcpa_rsp_if.source                      out_chan,
  input  logic                            cfg_we,
  input  logic [fcpa_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [fcpa_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import fcpa_pkg::*;

  localparam int IDX_W = $clog2(MAX_CHUNKS);
  localparam int CNT_W = IDX_W + 1;

  // configuration registers
  logic [ADDR_W-1:0]  cfg_base_r;
  logic [SIZE_W-1:0]  cfg_chunk_r;
  logic [COUNT_W-1:0] cfg_chunks_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_base_r   <= RST_BASE;
      cfg_chunk_r  <= RST_CHUNK;
      cfg_chunks_r <= RST_CHUNKS;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_BASE_ADDRESS:  cfg_base_r   <= cfg_wdata[ADDR_W-1:0];
        REG_CHUNK_BYTES:   cfg_chunk_r  <= cfg_wdata[SIZE_W-1:0];
        REG_CHUNKS_IN_USE: cfg_chunks_r <= cfg_wdata[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // effective pool size and chunk size
  logic [CNT_W-1:0]  pool_n;
  logic [SIZE_W-1:0] size_eff;

  assign pool_n   = (32'(cfg_chunks_r) > 32'(MAX_CHUNKS)) ? CNT_W'(MAX_CHUNKS)
                                                          : CNT_W'(cfg_chunks_r);
  assign size_eff = (cfg_chunk_r == '0) ? SIZE_W'(1) : cfg_chunk_r;

  // sequencer state
  state_t            state_r, state_nxt;
  logic [CNT_W-1:0]  fresh_r, fresh_nxt;
  logic [CNT_W-1:0]  scan_r, scan_nxt;
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  logic [ADDR_W-1:0] res_addr_r, res_addr_nxt;
  status_t           res_status_r, res_status_nxt;
  logic [MAX_CHUNKS-1:0] valid_r;

  logic [ADDR_W-1:0]   out_addr_r;
  logic [STATUS_W-1:0] out_status_r;
  logic                out_valid_r;
  logic                out_load;

  logic              valid_set, valid_clr;
  logic              ram_we, ram_re;
  logic [IDX_W-1:0]  ram_rdata;
  logic [IDX_W-1:0]  slot;
  logic              scan_in_range;
  logic              slot_valid;

  arith_ctrl_t       arith_ctrl;
  logic [ADDR_W-1:0] arith_a;
  logic [IDX_W-1:0]  arith_m;
  logic              arith_done;
  logic [ADDR_W-1:0] arith_res;

  assign slot          = scan_r[IDX_W-1:0];
  assign scan_in_range = scan_r < pool_n;
  assign slot_valid    = valid_r[slot];

  // next state and datapath controls
  always_comb begin
    state_nxt      = state_r;
    fresh_nxt      = fresh_r;
    scan_nxt       = scan_r;
    idx_nxt        = idx_r;
    res_addr_nxt   = res_addr_r;
    res_status_nxt = res_status_r;
    valid_set      = 1'b0;
    valid_clr      = 1'b0;
    ram_we         = 1'b0;
    ram_re         = 1'b0;
    arith_ctrl     = '{start: 1'b0, op: OP_MUL};
    arith_a        = cfg_base_r;
    arith_m        = fresh_r[IDX_W-1:0];
    out_load       = 1'b0;
    in_chan.ready  = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        in_chan.ready = 1'b1;
        if (in_chan.valid) begin
          res_addr_nxt = '0;
          scan_nxt     = '0;
          if (in_chan.mode == MODE_FREE) begin
            arith_ctrl = '{start: 1'b1, op: OP_DIV};
            arith_a    = in_chan.free_address - cfg_base_r;
            state_nxt  = S_DIV;
          end else if (fresh_r < pool_n) begin
            arith_ctrl = '{start: 1'b1, op: OP_MUL};
            fresh_nxt  = fresh_r + CNT_W'(1);
            state_nxt  = S_MUL;
          end else begin
            state_nxt = S_SCAN_A;
          end
        end
      end

      // look for the lowest recorded chunk
      S_SCAN_A: begin
        if (!scan_in_range) begin
          res_status_nxt = ST_NO_ROOM;
          state_nxt      = S_DONE;
        end else if (slot_valid) begin
          valid_clr = 1'b1;
          ram_re    = 1'b1;
          state_nxt = S_READ;
        end else begin
          scan_nxt = scan_r + CNT_W'(1);
        end
      end

      S_READ: begin
        arith_ctrl = '{start: 1'b1, op: OP_MUL};
        arith_m    = ram_rdata;
        state_nxt  = S_MUL;
      end

      S_MUL: begin
        if (arith_done) begin
          res_addr_nxt   = arith_res;
          res_status_nxt = ST_OK;
          state_nxt      = S_DONE;
        end
      end

      // quotient at or past the pool size means the address is outside
      S_DIV: begin
        if (arith_done) begin
          if (arith_res >= 32'(pool_n)) begin
            res_status_nxt = ST_FREE_REJ;
            state_nxt      = S_DONE;
          end else begin
            idx_nxt   = arith_res[IDX_W-1:0];
            state_nxt = S_SCAN_F;
          end
        end
      end

      // record the chunk in the lowest empty slot
      S_SCAN_F: begin
        if (!scan_in_range) begin
          res_status_nxt = ST_FREE_REJ;
          state_nxt      = S_DONE;
        end else if (!slot_valid) begin
          valid_set      = 1'b1;
          ram_we         = 1'b1;
          res_status_nxt = ST_OK;
          state_nxt      = S_DONE;
        end else begin
          scan_nxt = scan_r + CNT_W'(1);
        end
      end

      S_DONE: begin
        if (!out_valid_r || out_chan.ready) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      fresh_r <= '0;
      valid_r <= '0;
    end else begin
      state_r <= state_nxt;
      fresh_r <= fresh_nxt;
      if (valid_set) begin
        valid_r[slot] <= 1'b1;
      end else if (valid_clr) begin
        valid_r[slot] <= 1'b0;
      end
    end
    scan_r       <= scan_nxt;
    idx_r        <= idx_nxt;
    res_addr_r   <= res_addr_nxt;
    res_status_r <= res_status_nxt;
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
    if (out_load) begin
      out_addr_r   <= res_addr_r;
      out_status_r <= res_status_r;
    end
  end

  assign out_chan.valid         = out_valid_r;
  assign out_chan.chunk_address = out_addr_r;
  assign out_chan.status        = out_status_r;

  // slot chunk index table
  fcpa_ram #(
    .WIDTH (IDX_W),
    .DEPTH (MAX_CHUNKS)
  ) u_slot_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (slot),
    .wdata (idx_r),
    .re    (ram_re),
    .raddr (slot),
    .rdata (ram_rdata)
  );

  // shared multiply and divide unit
  fcpa_arith #(
    .IDX_W (IDX_W)
  ) u_arith (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctrl   (arith_ctrl),
    .opnd_a (arith_a),
    .size   (size_eff),
    .mult   (arith_m),
    .done   (arith_done),
    .result (arith_res)
  );

  // checks
  a_fresh_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fresh_r <= CNT_W'(MAX_CHUNKS))
    else $error("bump counter beyond pool capacity");

  a_done_when_waiting: assert property (@(posedge clk) disable iff (!rst_n)
    arith_done |-> (state_r == S_MUL || state_r == S_DIV))
    else $error("arithmetic result arrived with no request waiting");

  a_free_sets_one: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN_F && scan_in_range && !slot_valid) |=>
      ($countones(valid_r) == $past($countones(valid_r)) + 1))
    else $error("recording a free did not add exactly one slot");

  a_alloc_clears_one: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN_A && scan_in_range && slot_valid) |=>
      ($countones(valid_r) + 1 == $past($countones(valid_r))))
    else $error("table allocate did not empty exactly one slot");

endmodule

// ===== tb/alloc_checker.sv =====
`timescale 1ns / 1ps

module alloc_checker #(
  parameter int MAX_CHUNKS = fcpa_pkg::DEF_MAX_CHUNKS
) (
  input  logic                            clk,
  input  logic                            rst_n,
  fcpa_req_if                             req,
  fcpa_rsp_if                             rsp,
  input  logic                            cfg_we,
  input  logic [fcpa_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [fcpa_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output int                              fail_count,
  output int                              pending,
  output int                              checked
);
  import fcpa_pkg::*;

  localparam int IDX_W = $clog2(MAX_CHUNKS);

  typedef struct packed {
    logic [ADDR_W-1:0] chunk_address;
    status_t           status;
  } grant_t;

  // shadow copy of the registers and of the allocator state
  logic [ADDR_W-1:0]  base_addr;
  logic [SIZE_W-1:0]  chunk_len;
  logic [COUNT_W-1:0] pool_chunks;
  int unsigned        fresh_next;
  logic               slot_used  [MAX_CHUNKS];
  logic [IDX_W-1:0]   slot_chunk [MAX_CHUNKS];
  grant_t             expected_grants [$];

  initial begin
    fail_count = 0;
    pending    = 0;
    checked    = 0;
  end

  // address of a chunk, wrapping at 32 bits
  function automatic logic [ADDR_W-1:0] chunk_base(int unsigned idx, logic [31:0] sz);
    return ADDR_W'(64'(base_addr) + 64'(idx) * 64'(sz));
  endfunction

  // work out the grant for one request and update the shadow state
  task automatic predict_grant(input mode_t m, input logic [ADDR_W-1:0] fa,
                               output grant_t g);
    int unsigned       n;
    logic [31:0]       sz;
    logic [ADDR_W-1:0] offset;
    bit                done;
    n    = (pool_chunks > MAX_CHUNKS) ? MAX_CHUNKS : pool_chunks;
    sz   = (chunk_len == '0) ? 32'd1 : 32'(chunk_len);
    done = 1'b0;
    g.chunk_address = '0;
    g.status        = ST_OK;
    if (m == MODE_ALLOC) begin
      if (fresh_next < n) begin
        g.chunk_address = chunk_base(fresh_next, sz);
        fresh_next++;
      end else begin
        // bump counter used up: lowest recorded slot wins
        g.status = ST_NO_ROOM;
        for (int k = 0; k < n; k++) begin
          if (!done && slot_used[k]) begin
            done            = 1'b1;
            g.chunk_address = chunk_base(32'(slot_chunk[k]), sz);
            g.status        = ST_OK;
            slot_used[k]    = 1'b0;
          end
        end
      end
    end else begin
      offset   = fa - base_addr;
      g.status = ST_FREE_REJ;
      if (64'(offset) < 64'(n) * 64'(sz)) begin
        // record in the first empty slot, rejected when the table is full
        for (int k = 0; k < n; k++) begin
          if (!done && !slot_used[k]) begin
            done          = 1'b1;
            slot_used[k]  = 1'b1;
            slot_chunk[k] = IDX_W'(offset / sz);
            g.status      = ST_OK;
          end
        end
      end
    end
  endtask

  // observe config writes, requests and results
  always @(posedge clk) begin
    grant_t want;
    grant_t got;
    if (!rst_n) begin
      base_addr   = RST_BASE;
      chunk_len   = RST_CHUNK;
      pool_chunks = RST_CHUNKS;
      fresh_next  = 0;
      for (int k = 0; k < MAX_CHUNKS; k++) slot_used[k] = 1'b0;
      expected_grants.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_BASE_ADDRESS:  base_addr   = cfg_wdata[ADDR_W-1:0];
          REG_CHUNK_BYTES:   chunk_len   = cfg_wdata[SIZE_W-1:0];
          REG_CHUNKS_IN_USE: pool_chunks = cfg_wdata[COUNT_W-1:0];
          default: ;
        endcase
      end
      // result transaction against the oldest expectation
      if (rsp.valid && rsp.ready) begin
        if (expected_grants.size() == 0) begin
          $error("unexpected result: chunk_address %h status %0d",
                 rsp.chunk_address, rsp.status);
          fail_count++;
        end else begin
          want = expected_grants.pop_front();
          if (rsp.chunk_address !== want.chunk_address) begin
            $error("chunk_address mismatch: expected %h, actual %h",
                   want.chunk_address, rsp.chunk_address);
            fail_count++;
          end
          if (rsp.status !== want.status) begin
            $error("status mismatch: expected %0d, actual %0d", want.status, rsp.status);
            fail_count++;
          end
          checked++;
        end
      end
      // request transaction
      if (req.valid && req.ready) begin
        predict_grant(mode_t'(req.mode), req.free_address, got);
        expected_grants.push_back(got);
      end
      pending = expected_grants.size();
    end
  end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
  import fcpa_pkg::*;

  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int PHASES       = 10;
  localparam int PHASE_ITEMS  = 73;
  localparam int SETTLE_TAIL  = 120;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  int fail_count;
  int pending;
  int checked;

  int unsigned cycle_cnt;
  int unsigned src_idle_pct;
  int unsigned snk_stall_pct;
  int          alloc_sent;
  int          free_sent;
  int          settings;

  // current pool setting, mirrored for building in-pool addresses
  logic [ADDR_W-1:0]  cur_base;
  logic [SIZE_W-1:0]  cur_chunk;
  logic [COUNT_W-1:0] cur_count;

  int unsigned pool_plan [PHASES] = '{2, 5, 1, 8, 16, 64, 12, 127, 33, 4};

  fcpa_req_if req_if ();
  fcpa_rsp_if rsp_if ();

  fixed_chunk_pool_allocator i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (req_if),
    .out_chan  (rsp_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  alloc_checker i_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .req        (req_if),
    .rsp        (rsp_if),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .fail_count (fail_count),
    .pending    (pending),
    .checked    (checked)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // watchdog
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // result side back-pressure
  always @(negedge clk) begin
    rsp_if.ready <= ($urandom_range(99) >= snk_stall_pct);
  end

  // one register write, block idle
  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  // hold off requests until every grant is back
  task automatic drain();
    @(negedge clk);
    req_if.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic set_pool(input logic [ADDR_W-1:0] b, input logic [SIZE_W-1:0] c,
                          input logic [COUNT_W-1:0] n);
    drain();
    write_reg(REG_BASE_ADDRESS, CFG_DATA_W'(b));
    write_reg(REG_CHUNK_BYTES, CFG_DATA_W'(c));
    write_reg(REG_CHUNKS_IN_USE, CFG_DATA_W'(n));
    cur_base  = b;
    cur_chunk = c;
    cur_count = n;
    settings++;
  endtask

  // one request transaction with a random lead-in gap
  task automatic send_req(input mode_t m, input logic [ADDR_W-1:0] fa);
    @(negedge clk);
    while ($urandom_range(99) < src_idle_pct) begin
      req_if.valid <= 1'b0;
      @(negedge clk);
    end
    req_if.valid        <= 1'b1;
    req_if.mode         <= m;
    req_if.free_address <= fa;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
    if (m == MODE_ALLOC) alloc_sent++;
    else free_sent++;
  endtask

  // an address somewhere inside a chunk of the current pool
  function automatic logic [ADDR_W-1:0] inside_pool_addr();
    int unsigned n;
    int unsigned sz;
    longint      off;
    n  = (cur_count > DEF_MAX_CHUNKS) ? DEF_MAX_CHUNKS : cur_count;
    sz = (cur_chunk == '0) ? 1 : cur_chunk;
    if (n == 0) return $urandom;
    off = longint'($urandom_range(n - 1, 0)) * sz + $urandom_range(sz - 1, 0);
    return ADDR_W'(longint'(cur_base) + off);
  endfunction

  initial begin
    logic [ADDR_W-1:0] b;
    logic [SIZE_W-1:0] c;
    int unsigned       r;
    cycle_cnt     = 0;
    src_idle_pct  = 0;
    snk_stall_pct = 0;
    alloc_sent    = 0;
    free_sent     = 0;
    settings      = 1;
    cur_base      = RST_BASE;
    cur_chunk     = RST_CHUNK;
    cur_count     = RST_CHUNKS;
    rst_n               <= 1'b0;
    req_if.valid        <= 1'b0;
    req_if.mode         <= MODE_ALLOC;
    req_if.free_address <= '0;
    cfg_we              <= 1'b0;
    cfg_index           <= REG_BASE_ADDRESS;
    cfg_wdata           <= '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset setting: free of a chunk never handed out, free far outside, first fresh
    send_req(MODE_FREE, 32'h0000_0000);
    send_req(MODE_FREE, 32'hFFFF_FFFF);
    send_req(MODE_ALLOC, 32'hFFFF_FFFF);

    // three chunks of 21'h10_0000 bytes wrapping past the top of the address space
    set_pool(32'hFFFF_FFF0, SIZE_W'(21'h10_0000), COUNT_W'(3));
    send_req(MODE_ALLOC, 32'h0);
    send_req(MODE_ALLOC, 32'h0);
    send_req(MODE_ALLOC, 32'h0);
    send_req(MODE_ALLOC, 32'h0);
    // unaligned free, just below base, exactly one past the pool, last byte
    send_req(MODE_FREE, 32'hFFFF_FFF0 + 32'h10_0005);
    send_req(MODE_FREE, 32'hFFFF_FFEF);
    send_req(MODE_FREE, 32'hFFFF_FFF0 + 32'h30_0000);
    send_req(MODE_FREE, 32'hFFFF_FFF0 + 32'h2F_FFFF);
    send_req(MODE_FREE, 32'hFFFF_FFF0);
    // table full
    send_req(MODE_FREE, 32'hFFFF_FFF0);
    send_req(MODE_ALLOC, 32'h0);
    send_req(MODE_ALLOC, 32'h0);
    // double free of chunk zero
    send_req(MODE_FREE, 32'hFFFF_FFFF);
    send_req(MODE_ALLOC, 32'h0);
    send_req(MODE_ALLOC, 32'h0);
    send_req(MODE_ALLOC, 32'h0);

    // empty pool
    set_pool(32'hFFFF_FFF0, SIZE_W'(21'h10_0000), COUNT_W'(0));
    send_req(MODE_ALLOC, 32'h0);
    send_req(MODE_FREE, 32'hFFFF_FFF0);

    // zero chunk size and pool size above the limit
    set_pool(32'h0000_1000, SIZE_W'(0), COUNT_W'(127));
    send_req(MODE_ALLOC, 32'h0);
    send_req(MODE_FREE, 32'h0000_1001);

    // random phases, each with its own setting and idling pattern
    for (int p = 0; p < PHASES; p++) begin
      case (p % 4)
        0:       b = $urandom;
        1:       b = 32'hFFFF_FFFF;
        2:       b = 32'h0000_0000;
        default: b = $urandom & 32'hFFFF_F000;
      endcase
      case (p % 5)
        0:       c = SIZE_W'($urandom_range(64, 1));
        1:       c = SIZE_W'(1);
        2:       c = SIZE_W'(21'h10_0000);
        3:       c = SIZE_W'($urandom_range(21'h10_0000, 1));
        default: c = SIZE_W'($urandom_range(7, 0));
      endcase
      src_idle_pct  = 0;
      snk_stall_pct = 0;
      set_pool(b, c, COUNT_W'(pool_plan[p]));
      case (p % 4)
        1: src_idle_pct = 70;
        2: snk_stall_pct = 70;
        3: begin
          src_idle_pct  = 18;
          snk_stall_pct = 18;
        end
        default: ;
      endcase
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if ($urandom_range(99) < 2) drain();
        r = $urandom_range(99);
        if (r < 45) send_req(MODE_ALLOC, $urandom);
        else if (r < 85) send_req(MODE_FREE, inside_pool_addr());
        else send_req(MODE_FREE, $urandom);
      end
    end

    // wind down
    @(negedge clk);
    req_if.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_TAIL) @(negedge clk);

    $display("%0d allocate and %0d free requests over %0d pool settings, %0d grants checked",
             alloc_sent, free_sent, settings, checked);
    if (fail_count == 0 && pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
